// ===== src/assert_macros.svh =====
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define AST_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define AST_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== src/dip_pkg.sv =====
// ----------------------------------------------------------------------------
// dip_pkg
// Types and constants of the double integer power block.
// ----------------------------------------------------------------------------
package dip_pkg;

    localparam int EXP_BITS_DEF = 32;

    localparam logic [63:0] QNAN_BITS = 64'h7FF8_0000_0000_0000;
    localparam logic [63:0] ONE_BITS  = 64'h3FF0_0000_0000_0000;
    localparam logic [63:0] INF_BITS  = 64'h7FF0_0000_0000_0000;

    typedef enum logic {
        OP_MUL,
        OP_RECIP
    } t_op;

    typedef struct packed {
        logic [63:0]        base_bits;
        logic signed [31:0] exponent;
    } t_in;

    typedef struct packed {
        logic [63:0] result_bits;
        logic        undefined_flag;
    } t_out;

    typedef struct packed {
        logic        start;
        t_op         op;
        logic [63:0] a;
        logic [63:0] b;
    } t_fpu_req;

    typedef struct packed {
        logic        done;
        logic        busy;
        logic [63:0] res;
    } t_fpu_rsp;

endpackage

// ===== src/dip_fpu.sv =====
// ----------------------------------------------------------------------------
// dip_fpu
// Iterative binary64 unit: multiply a*b or reciprocal 1/b, round to nearest
// even, with one shared normalize and round back end.
// ----------------------------------------------------------------------------
module dip_fpu (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dip_pkg::t_fpu_req i_req,
    output dip_pkg::t_fpu_rsp o_rsp
);
    import dip_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DNORM,
        S_DIV,
        S_NORM,
        S_DENORM,
        S_ROUND
    } t_state;

    t_state              r_state;
    logic [5:0]          r_cnt;
    logic [105:0]        r_p;
    logic signed [13:0]  r_e;
    logic                r_sign;
    logic [52:0]         r_ma;
    logic [52:0]         r_mb;
    logic [55:0]         r_q;
    logic [54:0]         r_rem;
    logic [63:0]         r_res;
    logic                r_done;

    logic [10:0] ea, eb;
    logic [51:0] fa, fb;
    logic        a_nan, a_inf, a_zero, b_nan, b_inf, b_zero;
    logic        s_mul;
    logic [26:0] pp_x, pp_y;
    logic [53:0] pp;
    logic [105:0] pp_sh;
    logic        ge;
    logic [54:0] n_rem;
    logic [55:0] n_q;
    logic [62:0] mag63;
    logic        up;
    logic        n_done;

    always_comb begin
        ea     = i_req.a[62:52];
        fa     = i_req.a[51:0];
        eb     = i_req.b[62:52];
        fb     = i_req.b[51:0];
        a_nan  = (ea == 11'h7FF) && (fa != '0);
        a_inf  = (ea == 11'h7FF) && (fa == '0);
        a_zero = (ea == '0) && (fa == '0);
        b_nan  = (eb == 11'h7FF) && (fb != '0);
        b_inf  = (eb == 11'h7FF) && (fb == '0);
        b_zero = (eb == '0) && (fb == '0);
        s_mul  = i_req.a[63] ^ i_req.b[63];
    end

    // Done pulses after round, or right after a start that hits a special operand.
    always_comb begin
        n_done = 1'b0;
        if (r_state == S_ROUND) begin
            n_done = 1'b1;
        end else if ((r_state == S_IDLE) && i_req.start) begin
            if (i_req.op == OP_MUL) begin
                n_done = a_nan || b_nan || a_inf || b_inf || a_zero || b_zero;
            end else begin
                n_done = b_nan || b_inf || b_zero;
            end
        end
    end

    // Partial product: cnt selects the 27-bit halves of each mantissa.
    always_comb begin
        pp_x = r_cnt[1] ? r_ma[52:26] : {1'b0, r_ma[25:0]};
        pp_y = r_cnt[0] ? r_mb[52:26] : {1'b0, r_mb[25:0]};
        pp   = pp_x * pp_y;
        unique case (r_cnt[1:0])
            2'd0:    pp_sh = {52'd0, pp};
            2'd3:    pp_sh = {pp, 52'd0};
            default: pp_sh = {26'd0, pp, 26'd0};
        endcase
    end

    // One restoring division step.
    always_comb begin
        ge    = r_rem >= {2'b00, r_mb};
        n_rem = ge ? ((r_rem - {2'b00, r_mb}) << 1) : (r_rem << 1);
        n_q   = {r_q[54:0], ge};
    end

    always_comb begin
        mag63 = {(r_p[105] ? r_e[10:0] : 11'd0), r_p[104:53]};
        up    = r_p[52] & ((|r_p[51:0]) | r_p[53]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= n_done;
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.start) begin
                        if (i_req.op == OP_MUL) begin
                            r_sign <= s_mul;
                            if (a_nan || b_nan || (a_inf && b_zero) || (a_zero && b_inf)) begin
                                r_res  <= QNAN_BITS;
                            end else if (a_inf || b_inf) begin
                                r_res  <= {s_mul, INF_BITS[62:0]};
                            end else if (a_zero || b_zero) begin
                                r_res  <= {s_mul, 63'd0};
                            end else begin
                                r_ma    <= {(ea != '0), fa};
                                r_mb    <= {(eb != '0), fb};
                                r_e     <= 14'(signed'({3'b000, (ea == '0) ? 11'd1 : ea}))
                                         + 14'(signed'({3'b000, (eb == '0) ? 11'd1 : eb}))
                                         - 14'sd1022;
                                r_p     <= '0;
                                r_cnt   <= '0;
                                r_state <= S_MUL;
                            end
                        end else begin
                            r_sign <= i_req.b[63];
                            if (b_nan) begin
                                r_res  <= QNAN_BITS;
                            end else if (b_inf) begin
                                r_res  <= {i_req.b[63], 63'd0};
                            end else if (b_zero) begin
                                r_res  <= {i_req.b[63], INF_BITS[62:0]};
                            end else begin
                                r_mb    <= {(eb != '0), fb};
                                r_e     <= 14'(signed'({3'b000, (eb == '0) ? 11'd1 : eb}));
                                r_state <= S_DNORM;
                            end
                        end
                    end
                end
                S_MUL: begin
                    r_p   <= r_p + pp_sh;
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt[1:0] == 2'd3) begin
                        r_state <= S_NORM;
                    end
                end
                S_DNORM: begin
                    if (!r_mb[52]) begin
                        r_mb <= {r_mb[51:0], 1'b0};
                        r_e  <= r_e - 14'sd1;
                    end else begin
                        r_rem   <= 55'd1 << 52;
                        r_q     <= '0;
                        r_cnt   <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem <= n_rem;
                    r_q   <= n_q;
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd55) begin
                        r_p     <= {n_q, (n_rem != '0), 49'd0};
                        r_e     <= 14'sd2046 - r_e;
                        r_state <= S_NORM;
                    end
                end
                S_NORM: begin
                    if (!r_p[105] && (r_e > 14'sd1)) begin
                        r_p <= {r_p[104:0], 1'b0};
                        r_e <= r_e - 14'sd1;
                    end else begin
                        r_state <= S_DENORM;
                    end
                end
                S_DENORM: begin
                    // Tiny values: collapse far right shifts into one sticky bit.
                    if (r_e < -14'sd60) begin
                        r_p <= {105'd0, |r_p};
                        r_e <= 14'sd1;
                    end else if (r_e < 14'sd1) begin
                        r_p <= {1'b0, r_p[105:2], r_p[1] | r_p[0]};
                        r_e <= r_e + 14'sd1;
                    end else begin
                        r_state <= S_ROUND;
                    end
                end
                S_ROUND: begin
                    if (r_p[105] && (r_e > 14'sd2046)) begin
                        r_res <= {r_sign, INF_BITS[62:0]};
                    end else begin
                        r_res <= {r_sign, mag63 + {62'd0, up}};
                    end
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.busy = (r_state != S_IDLE);
    assign o_rsp.res  = r_res;

endmodule

// ===== src/double_integer_power.sv =====
// ----------------------------------------------------------------------------
// double_integer_power
// Binary64 base raised to a signed integer power by square-and-multiply.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_valid / o_stall carries one t_in transaction: base_bits
//   and exponent. Output channel o_valid / i_stall returns one t_out
//   transaction per input: result_bits and undefined_flag.
//   A transaction moves on a rising edge with valid high and stall low.
//   Sequence: a zero exponent or zero to the zero goes straight to the done
//   state. Otherwise each set exponent bit costs one multiply and each bit
//   below the top one costs one square; each runs in the shared FPU through
//   issue, partial-product accumulation, normalize, denormalize check and
//   round, with one sequencer pass per exponent bit. A negative exponent
//   adds one reciprocal (56 restoring division steps) unless the result
//   is zero, whose reciprocal is infinity of the same sign.
//   Throughput: one transaction at a time; o_stall is high while the
//   sequencer works. A finished result waits in the output register while
//   the receiver stalls, and a new input is taken meanwhile.
//   Reset: synchronous active-low; the sequencer, FPU and output valid clear.
// ----------------------------------------------------------------------------
module double_integer_power #(
    parameter int EXP_BITS = dip_pkg::EXP_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  dip_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_stall,
    output dip_pkg::t_out o_data
);
    import dip_pkg::*;

    `include "assert_macros.svh"

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOP,
        S_WACC,
        S_WSQ,
        S_WDIV,
        S_DONE
    } t_state;

    t_state                r_state;
    logic [EXP_BITS-1:0]   r_mag;
    logic                  r_neg;
    logic [63:0]           r_acc;
    logic [63:0]           r_sq;
    logic [63:0]           r_res;
    logic                  r_undef;
    logic                  r_out_valid;
    t_out                  r_out;

    t_fpu_req              fpu_req;
    t_fpu_rsp              fpu_rsp;

    logic                  in_take;
    logic [63:0]           exp_ext;
    logic [EXP_BITS-1:0]   ebits;
    logic                  e_neg;
    logic [EXP_BITS-1:0]   n_mag;
    logic                  base_zero;
    logic                  out_free;
    logic                  res_nan;
    logic                  n_out_valid;

    dip_fpu u_fpu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (fpu_req),
        .o_rsp   (fpu_rsp)
    );

    assign in_take = i_valid && !o_stall;
    assign o_stall = (r_state != S_IDLE);

    // Sign-extend, keep the low EXP_BITS bits, take the unsigned magnitude.
    always_comb begin
        exp_ext   = {{32{i_data.exponent[31]}}, i_data.exponent};
        ebits     = exp_ext[EXP_BITS-1:0];
        e_neg     = ebits[EXP_BITS-1];
        n_mag     = e_neg ? (~ebits + {{(EXP_BITS-1){1'b0}}, 1'b1}) : ebits;
        base_zero = (i_data.base_bits[62:0] == '0);
    end

    // Issue FPU work from the sequencer states.
    always_comb begin
        fpu_req.start = 1'b0;
        fpu_req.op    = OP_MUL;
        fpu_req.a     = r_acc;
        fpu_req.b     = r_sq;
        unique case (r_state)
            S_LOOP: begin
                if (r_mag == '0) begin
                    fpu_req.start = r_neg && (r_acc[62:0] != '0);
                    fpu_req.op    = OP_RECIP;
                    fpu_req.b     = r_acc;
                end else if (r_mag[0]) begin
                    fpu_req.start = 1'b1;
                end else begin
                    fpu_req.start = 1'b1;
                    fpu_req.a     = r_sq;
                end
            end
            S_WACC: begin
                // Square right after the accumulate when higher bits remain.
                fpu_req.start = fpu_rsp.done && (r_mag[EXP_BITS-1:1] != '0);
                fpu_req.a     = r_sq;
            end
            default: ;
        endcase
    end

    assign out_free = !r_out_valid || !i_stall;
    assign res_nan  = (r_res[62:52] == 11'h7FF) && (r_res[51:0] != '0);

    // Load the output register from S_DONE; drop the transaction once taken.
    always_comb begin
        n_out_valid = r_out_valid;
        if ((r_state == S_DONE) && out_free) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            unique case (r_state)
                S_IDLE: begin
                    if (in_take) begin
                        r_mag   <= n_mag;
                        r_neg   <= e_neg;
                        r_acc   <= ONE_BITS;
                        r_sq    <= i_data.base_bits;
                        r_undef <= base_zero && (n_mag == '0);
                        if (base_zero && (n_mag == '0)) begin
                            r_res   <= QNAN_BITS;
                            r_state <= S_DONE;
                        end else if (n_mag == '0) begin
                            r_res   <= ONE_BITS;
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_LOOP;
                        end
                    end
                end
                S_LOOP: begin
                    if (r_mag == '0) begin
                        if (!r_neg) begin
                            r_res   <= r_acc;
                            r_state <= S_DONE;
                        end else if (r_acc[62:0] == '0) begin
                            // Reciprocal of a signed zero: infinity of that sign.
                            r_res   <= {r_acc[63], INF_BITS[62:0]};
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_WDIV;
                        end
                    end else if (r_mag[0]) begin
                        r_state <= S_WACC;
                    end else begin
                        r_state <= S_WSQ;
                    end
                end
                S_WACC: begin
                    if (fpu_rsp.done) begin
                        r_acc <= fpu_rsp.res;
                        if (r_mag[EXP_BITS-1:1] == '0) begin
                            r_mag   <= '0;
                            r_state <= S_LOOP;
                        end else begin
                            r_state <= S_WSQ;
                        end
                    end
                end
                S_WSQ: begin
                    if (fpu_rsp.done) begin
                        r_sq    <= fpu_rsp.res;
                        r_mag   <= r_mag >> 1;
                        r_state <= S_LOOP;
                    end
                end
                S_WDIV: begin
                    if (fpu_rsp.done) begin
                        r_res   <= fpu_rsp.res;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    // Hold until the output register is free; canonicalize NaN.
                    if (out_free) begin
                        r_out.result_bits    <= res_nan ? QNAN_BITS : r_res;
                        r_out.undefined_flag <= r_undef;
                        r_state              <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    `AST_IMPL(a_undef_nan, i_clk, i_rst_n, o_valid && o_data.undefined_flag, o_data.result_bits == QNAN_BITS)
    `AST_NEXT(a_busy_after_take, i_clk, i_rst_n, in_take, o_stall)
    `AST_IMPL(a_fpu_start_idle, i_clk, i_rst_n, fpu_req.start, !fpu_rsp.busy)
    `AST_IMPL(a_done_while_wait, i_clk, i_rst_n, fpu_rsp.done, r_state == S_WACC || r_state == S_WSQ || r_state == S_WDIV)

endmodule
